@@ rtl/battery_undervoltage_monitor_macros.svh @@
// Assertion macros shared by the battery undervoltage monitor RTL.
`ifndef BATTERY_UNDERVOLTAGE_MONITOR_MACROS_SVH
`define BATTERY_UNDERVOLTAGE_MONITOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BUM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BUM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bum_pkg.sv @@
// Types, constants and helpers of the battery undervoltage monitor.
`timescale 1ns / 1ps
package bum_pkg;

  localparam int unsigned HistoryDepth = 64;
  localparam int unsigned MvW          = 16;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned InDataW      = 48;
  localparam int unsigned OutDataW     = 24;

  localparam logic [MvW-1:0] CriticalReset = 16'd7000;
  localparam logic [MvW-1:0] WarningReset  = 16'd11500;
  localparam logic [MvW-1:0] DeadbandReset = 16'd50;
  localparam logic [MvW-1:0] WindowReset   = 16'd2000;
  localparam logic           AutoReset     = 1'b1;

  localparam logic FuncSample = 1'b0;
  localparam logic FuncCheck  = 1'b1;

  typedef enum logic [1:0] {
    LVL_UNKNOWN  = 2'd0,
    LVL_CRITICAL = 2'd1,
    LVL_WARNING  = 2'd2,
    LVL_NORMAL   = 2'd3
  } level_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_CRITICAL     = 3'd0,
    CFG_WARNING      = 3'd1,
    CFG_DEADBAND     = 3'd2,
    CFG_WINDOW       = 3'd3,
    CFG_AUTO_DISABLE = 3'd4
  } cfg_addr_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_MUL   = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic             start;
    logic [TimeW-1:0] now_ms;
    logic [MvW-1:0]   window_ms;
  } sweep_req_t;

  typedef struct packed {
    logic             en;
    logic [TimeW-1:0] now_ms;
    logic [MvW-1:0]   mv;
  } hist_wr_t;

  function automatic level_e classify(input logic [MvW-1:0] mv,
                                      input logic [MvW-1:0] crit,
                                      input logic [MvW-1:0] warn);
    level_e lvl;
    if (mv == '0) begin
      lvl = LVL_UNKNOWN;
    end else if (mv <= crit) begin
      lvl = LVL_CRITICAL;
    end else if (mv <= warn) begin
      lvl = LVL_WARNING;
    end else begin
      lvl = LVL_NORMAL;
    end
    return lvl;
  endfunction

endpackage

@@ rtl/bum_history.sv @@
// Reading history memory with the window sweep that sums readings in the time window.
`timescale 1ns / 1ps
`include "battery_undervoltage_monitor_macros.svh"
module bum_history #(
  parameter int unsigned HistoryDepth = bum_pkg::HistoryDepth,
  localparam int unsigned IdxW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1,
  localparam int unsigned CntW = $clog2(HistoryDepth + 1),
  localparam int unsigned SumW = bum_pkg::MvW + CntW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bum_pkg::hist_wr_t    wr_i,
  input  logic [IdxW-1:0]      wr_slot_i,
  input  bum_pkg::sweep_req_t  req_i,
  input  logic [CntW-1:0]      count_i,
  output logic                 done_o,
  output logic [SumW-1:0]      sum_o,
  output logic [CntW-1:0]      hits_o
);

  localparam int unsigned EntryW = bum_pkg::TimeW + bum_pkg::MvW;

  logic [EntryW-1:0] mem [HistoryDepth];

  logic                     busy_q;
  logic                     done_q;
  logic                     rd_vld_q;
  logic [CntW-1:0]          rd_idx_q;
  logic [EntryW-1:0]        rd_data_q;
  logic [bum_pkg::TimeW-1:0] now_q;
  logic [bum_pkg::MvW-1:0]  win_q;
  logic [SumW-1:0]          sum_q;
  logic [CntW-1:0]          hits_q;

  logic                      issue;
  logic [bum_pkg::TimeW-1:0] age;
  logic                      in_window;

  assign issue     = busy_q && (rd_idx_q < count_i);
  assign age       = now_q - rd_data_q[EntryW-1:bum_pkg::MvW];
  assign in_window = age <= {{(bum_pkg::TimeW - bum_pkg::MvW){1'b0}}, win_q};

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_slot_i] <= {wr_i.now_ms, wr_i.mv};
    end
    if (issue) begin
      rd_data_q <= mem[rd_idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      now_q    <= '0;
      win_q    <= '0;
      sum_q    <= '0;
      hits_q   <= '0;
    end else begin
      done_q   <= 1'b0;
      rd_vld_q <= issue;
      if (req_i.start) begin
        busy_q   <= 1'b1;
        rd_idx_q <= '0;
        now_q    <= req_i.now_ms;
        win_q    <= req_i.window_ms;
        sum_q    <= '0;
        hits_q   <= '0;
      end else if (busy_q) begin
        if (issue) begin
          rd_idx_q <= rd_idx_q + CntW'(1);
        end
        if (rd_vld_q && in_window) begin
          sum_q  <= sum_q + SumW'(rd_data_q[bum_pkg::MvW-1:0]);
          hits_q <= hits_q + CntW'(1);
        end
        if (!issue && !rd_vld_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;
  assign hits_o = hits_q;

  `BUM_ASSERT_NOW(a_no_write_in_sweep, busy_q || req_i.start, !wr_i.en, "history written during sweep")
  `BUM_ASSERT_NOW(a_hits_bounded, busy_q, hits_q <= rd_idx_q, "more hits than entries read")
  `BUM_ASSERT_NEXT(a_done_ends_sweep, done_q, !busy_q || req_i.start, "sweep busy after done")

endmodule

@@ rtl/battery_undervoltage_monitor.sv @@
// Top level of the battery undervoltage monitor: stream ports, settings, level and control.
`timescale 1ns / 1ps
`include "battery_undervoltage_monitor_macros.svh"
// Takes voltage samples and sustained-voltage checks as stream transfers and returns one
// result per item. A sample result is ready in the cycle after its transfer. A check sweeps
// the reading history memory one entry per cycle, as that memory has a single read port,
// then multiplies once in the multiply state and loads its result from the done state.
// A new item is taken only in the idle state and once the previous result has left the
// output register or leaves in that cycle. The user must write settings through the cfg
// port only while no item is in flight; the block itself does not enforce this. A write to
// the thresholds does not reclassify the held level until the next sample stored in history.
module battery_undervoltage_monitor #(
  parameter int unsigned HistoryDepth = bum_pkg::HistoryDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [15:0] sample_mv, [47:16] now_ms
  input  logic [bum_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] func
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] level, [2] level_changed, [3] voltage_alert, [4] disable_request,
  // [20:5] voltage_now_mv, [23:21] zero
  output logic [bum_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bum_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [bum_pkg::MvW-1:0]        cfg_data_i
);

  localparam int unsigned IdxW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int unsigned CntW = $clog2(HistoryDepth + 1);
  localparam int unsigned SumW = bum_pkg::MvW + CntW;
  localparam int unsigned MvW  = bum_pkg::MvW;

  logic [MvW-1:0] critical_q, warning_q, deadband_q, window_q;
  logic           auto_q;

  bum_pkg::state_e state_q, state_d;
  bum_pkg::level_e level_q, new_level;
  logic [MvW-1:0]  volt_q;
  logic [IdxW-1:0] slot_q;
  logic [CntW-1:0] count_q;
  logic [SumW-1:0] prod_q;

  logic           out_valid_q;
  bum_pkg::level_e out_level_q;
  logic           out_changed_q, out_alert_q, out_disable_q;
  logic [MvW-1:0] out_volt_q;

  logic                      in_ready, accept, take, changed, alert, sus_crit;
  logic                      load_sample, load_check;
  logic [MvW-1:0]            sample_mv, diff;
  logic [bum_pkg::TimeW-1:0] now_ms;
  bum_pkg::sweep_req_t       req;
  bum_pkg::hist_wr_t         wr;
  logic                      sweep_done;
  logic [SumW-1:0]           sum;
  logic [CntW-1:0]           hits;

  assign sample_mv = s_axis_tdata_i[MvW-1:0];
  assign now_ms    = s_axis_tdata_i[bum_pkg::InDataW-1:MvW];
  assign in_ready  = (state_q == bum_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept    = s_axis_tvalid_i && in_ready;
  assign diff      = (sample_mv > volt_q) ? sample_mv - volt_q : volt_q - sample_mv;
  assign take      = diff > deadband_q;
  assign new_level = bum_pkg::classify(sample_mv, critical_q, warning_q);
  assign changed   = new_level != level_q;
  assign alert     = changed && ((new_level == bum_pkg::LVL_CRITICAL) ||
                                 (new_level == bum_pkg::LVL_WARNING));
  assign sus_crit  = (level_q == bum_pkg::LVL_CRITICAL) && auto_q &&
                     (sum != '0) && (sum <= prod_q);

  assign load_sample = accept && (s_axis_tuser_i == bum_pkg::FuncSample);
  assign load_check  = state_q == bum_pkg::ST_DONE;

  assign req.start     = accept && (s_axis_tuser_i == bum_pkg::FuncCheck);
  assign req.now_ms    = now_ms;
  assign req.window_ms = window_q;
  assign wr.en         = load_sample && take;
  assign wr.now_ms     = now_ms;
  assign wr.mv         = sample_mv;

  bum_history #(
    .HistoryDepth(HistoryDepth)
  ) u_history (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .wr_slot_i(slot_q),
    .req_i    (req),
    .count_i  (count_q),
    .done_o   (sweep_done),
    .sum_o    (sum),
    .hits_o   (hits)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      bum_pkg::ST_IDLE:  if (req.start) state_d = bum_pkg::ST_SWEEP;
      bum_pkg::ST_SWEEP: if (sweep_done) state_d = bum_pkg::ST_MUL;
      bum_pkg::ST_MUL:   state_d = bum_pkg::ST_DONE;
      bum_pkg::ST_DONE:  state_d = bum_pkg::ST_IDLE;
      default:           state_d = bum_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bum_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      critical_q <= bum_pkg::CriticalReset;
      warning_q  <= bum_pkg::WarningReset;
      deadband_q <= bum_pkg::DeadbandReset;
      window_q   <= bum_pkg::WindowReset;
      auto_q     <= bum_pkg::AutoReset;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        bum_pkg::CFG_CRITICAL:     critical_q <= cfg_data_i;
        bum_pkg::CFG_WARNING:      warning_q  <= cfg_data_i;
        bum_pkg::CFG_DEADBAND:     deadband_q <= cfg_data_i;
        bum_pkg::CFG_WINDOW:       window_q   <= cfg_data_i;
        bum_pkg::CFG_AUTO_DISABLE: auto_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= bum_pkg::LVL_UNKNOWN;
      volt_q  <= '0;
      slot_q  <= '0;
      count_q <= '0;
    end else if (wr.en) begin
      level_q <= new_level;
      volt_q  <= sample_mv;
      slot_q  <= (slot_q == IdxW'(HistoryDepth - 1)) ? '0 : slot_q + IdxW'(1);
      if (count_q != CntW'(HistoryDepth)) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bum_pkg::ST_MUL) begin
      prod_q <= SumW'(critical_q) * SumW'(hits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_sample || load_check) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_sample) begin
      out_level_q   <= take ? new_level : level_q;
      out_changed_q <= take && changed;
      out_alert_q   <= take && alert;
      out_disable_q <= 1'b0;
      out_volt_q    <= take ? sample_mv : volt_q;
    end else if (load_check) begin
      out_level_q   <= level_q;
      out_changed_q <= 1'b0;
      out_alert_q   <= 1'b0;
      out_disable_q <= sus_crit;
      out_volt_q    <= volt_q;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_volt_q, out_disable_q, out_alert_q, out_changed_q,
                            out_level_q};

  `BUM_ASSERT_NOW(a_ready_only_idle, s_axis_tready_o, state_q == bum_pkg::ST_IDLE, "ready outside idle")
  `BUM_ASSERT_NOW(a_alert_needs_change, out_valid_q && out_alert_q, out_changed_q, "alert without level change")
  `BUM_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= CntW'(HistoryDepth), "stored count overflow")
  `BUM_ASSERT_NEXT(a_check_result, state_q == bum_pkg::ST_DONE, m_axis_tvalid_o && !out_changed_q, "check result not loaded")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench of the battery undervoltage monitor: scoreboard-checked directed and random traffic.
module tb;
  import bum_pkg::*;

  localparam logic [CfgAddrW-1:0] CfgSpare = 3'd7;

  typedef struct packed {
    level_e         lvl;
    logic           changed;
    logic           alert;
    logic           dis_req;
    logic [MvW-1:0] mv;
  } monitor_result_t;

  class level_scoreboard;
    logic [MvW-1:0]   crit_mv;
    logic [MvW-1:0]   warn_mv;
    logic [MvW-1:0]   band_mv;
    logic [MvW-1:0]   win_ms;
    logic             auto_on;
    logic [TimeW-1:0] stamp_mem [HistoryDepth];
    logic [MvW-1:0]   volt_mem [HistoryDepth];
    int unsigned      next_slot;
    int unsigned      fill;
    logic [MvW-1:0]   held_mv;
    level_e           held_lvl;
    monitor_result_t  result_q [$];
    int unsigned      errors;

    function new();
      crit_mv   = CriticalReset;
      warn_mv   = WarningReset;
      band_mv   = DeadbandReset;
      win_ms    = WindowReset;
      auto_on   = AutoReset;
      next_slot = 0;
      fill      = 0;
      held_mv   = '0;
      held_lvl  = LVL_UNKNOWN;
      errors    = 0;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] idx, logic [MvW-1:0] val);
      case (idx)
        CFG_CRITICAL:     crit_mv = val;
        CFG_WARNING:      warn_mv = val;
        CFG_DEADBAND:     band_mv = val;
        CFG_WINDOW:       win_ms  = val;
        CFG_AUTO_DISABLE: auto_on = val[0];
        default: ;
      endcase
    endfunction

    function void note_item(logic func, logic [MvW-1:0] mv, logic [TimeW-1:0] now);
      monitor_result_t  res;
      logic [MvW-1:0]   diff;
      logic [TimeW-1:0] age;
      logic [TimeW-1:0] sum;
      logic [TimeW-1:0] cap;
      level_e           lvl;
      res.changed = 1'b0;
      res.alert   = 1'b0;
      res.dis_req = 1'b0;
      if (func == FuncSample) begin
        diff = (mv > held_mv) ? mv - held_mv : held_mv - mv;
        if (diff > band_mv) begin
          held_mv              = mv;
          stamp_mem[next_slot] = now;
          volt_mem[next_slot]  = mv;
          next_slot            = (next_slot + 1) % HistoryDepth;
          if (fill < HistoryDepth) fill++;
          if (mv == '0) lvl = LVL_UNKNOWN;
          else if (mv <= crit_mv) lvl = LVL_CRITICAL;
          else if (mv <= warn_mv) lvl = LVL_WARNING;
          else lvl = LVL_NORMAL;
          if (lvl != held_lvl) begin
            held_lvl    = lvl;
            res.changed = 1'b1;
            res.alert   = (lvl == LVL_CRITICAL) || (lvl == LVL_WARNING);
          end
        end
      end else if (held_lvl == LVL_CRITICAL && auto_on) begin
        sum = '0;
        cap = '0;
        // compare against critical * count without forming the average
        for (int i = 0; i < fill; i++) begin
          age = now - stamp_mem[i];
          if (age <= win_ms) begin
            sum += volt_mem[i];
            cap += crit_mv;
          end
        end
        res.dis_req = (sum != 0) && (sum <= cap);
      end
      res.lvl = held_lvl;
      res.mv  = held_mv;
      result_q.push_back(res);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      monitor_result_t want;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %h", $time, data);
        return;
      end
      want = result_q.pop_front();
      compare("level", want.lvl, data[1:0]);
      compare("level_changed", want.changed, data[2]);
      compare("voltage_alert", want.alert, data[3]);
      compare("disable_request", want.dis_req, data[4]);
      compare("voltage_now_mv", want.mv, data[20:5]);
      compare("pad", 0, data[23:21]);
    endfunction
  endclass

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_valid   = 1'b0;
  logic [InDataW-1:0]  s_data    = '0;
  logic                s_user    = 1'b0;
  logic                m_ready   = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [MvW-1:0]      cfg_data  = '0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_ready_o;

  int unsigned         src_idle_pct = 21;
  int unsigned         dst_idle_pct = 55;
  int unsigned         hold_left    = 0;
  logic [TimeW-1:0]    clock_ms     = '0;
  logic [MvW-1:0]      aim_mv       = '0;
  level_scoreboard     board;

  battery_undervoltage_monitor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) board.check_result(m_axis_tdata_o);
    if (hold_left > 0) begin
      m_ready <= 1'b0;
      hold_left--;
    end else begin
      m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  task automatic send_item(input logic func, input logic [MvW-1:0] mv,
                           input logic [TimeW-1:0] now);
    if ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {now, mv};
    s_user  <= func;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_item(func, mv, now);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (board.result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [MvW-1:0] crit, input logic [MvW-1:0] warn,
                               input logic [MvW-1:0] band, input logic [MvW-1:0] win,
                               input logic auto_on);
    logic [MvW-1:0]      vals [6];
    logic [CfgAddrW-1:0] idx [6];
    vals = '{crit, warn, band, win, {15'b0, auto_on}, 16'($urandom())};
    idx  = '{CFG_CRITICAL, CFG_WARNING, CFG_DEADBAND, CFG_WINDOW, CFG_AUTO_DISABLE, CfgSpare};
    drain();
    repeat (8) @(posedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      board.set_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int unsigned n);
    logic             func;
    logic [MvW-1:0]   mv;
    logic [TimeW-1:0] now;
    int unsigned      pick;
    int               span;
    for (int unsigned k = 0; k < n; k++) begin
      // retarget the voltage walk now and then, half the time to at or just below the critical threshold
      if (k == 0 || $urandom_range(39) == 0) begin
        pick = $urandom_range(3);
        if (pick < 2) begin
          span   = int'(board.crit_mv) - int'($urandom_range(400));
          aim_mv = (span < 0) ? '0 : span[MvW-1:0];
        end else if (pick == 2) begin
          aim_mv = board.warn_mv;
        end else begin
          aim_mv = 16'($urandom());
        end
      end
      pick = $urandom_range(99);
      if (pick < 4) clock_ms = clock_ms + $urandom();
      else if (pick < 8) clock_ms = clock_ms - $urandom_range(500, 1);
      else clock_ms = clock_ms + $urandom_range(120);
      now  = clock_ms;
      func = ($urandom_range(99) < 30) ? FuncCheck : FuncSample;
      if (func == FuncCheck && $urandom_range(19) == 0) now = $urandom();
      pick = $urandom_range(99);
      if (pick < 40) begin
        span = int'(aim_mv) + int'($urandom_range(600)) - 300;
        mv   = (span < 0) ? '0 : (span > 65535) ? '1 : span[MvW-1:0];
      end else if (pick < 55) begin
        span = int'($urandom_range(int'(board.band_mv) + 2));
        span = ($urandom_range(1) == 0) ? int'(board.held_mv) + span
                                        : int'(board.held_mv) - span;
        mv   = (span < 0) ? '0 : (span > 65535) ? '1 : span[MvW-1:0];
      end else if (pick < 65) begin
        case ($urandom_range(3))
          0: mv = board.crit_mv;
          1: mv = board.crit_mv + 1'b1;
          2: mv = board.warn_mv;
          default: mv = board.warn_mv + 1'b1;
        endcase
      end else if (pick < 70) begin
        mv = '0;
      end else begin
        mv = 16'($urandom());
      end
      send_item(func, mv, now);
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(FuncCheck,  16'hFFFF, 32'd0);
    send_item(FuncSample, 16'd0,     32'd0);
    send_item(FuncSample, 16'd65535, 32'd0);
    send_item(FuncSample, 16'd65500, 32'd5);
    send_item(FuncSample, 16'd65484, 32'd6);
    send_item(FuncSample, 16'd11500, 32'd10);
    send_item(FuncSample, 16'd11501, 32'd15);
    send_item(FuncSample, 16'd7001,  32'd20);
    send_item(FuncSample, 16'd6000,  32'd5000);
    send_item(FuncSample, 16'd7000,  32'd5100);
    send_item(FuncCheck,  16'h0000, 32'd5200);
    send_item(FuncCheck,  16'hFFFF, 32'd4000);
    send_item(FuncSample, 16'd30000, 32'd6000);
    send_item(FuncSample, 16'd5000,  32'd6100);
    send_item(FuncCheck,  16'h5555, 32'd6200);
    send_item(FuncCheck,  16'hAAAA, 32'd7500);
    send_item(FuncSample, 16'd0,     32'd7600);
    send_item(FuncCheck,  16'h0000, 32'd7600);
    send_item(FuncSample, 16'd1,     32'hFFFF_FFFF);
    send_item(FuncCheck,  16'hFFFF, 32'h0000_0100);
    send_item(FuncSample, 16'd65535, 32'hFFFF_FFFF);
    send_item(FuncCheck,  16'h0000, 32'hFFFF_FFFF);

    apply_setting(16'd3000, 16'd9000, 16'd10, 16'hFFFF, 1'b1);
    random_items(400);
    apply_setting(16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 1'b1);
    random_items(350);

    src_idle_pct = 55;
    dst_idle_pct = 21;
    apply_setting(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    random_items(60);
    apply_setting(16'd12000, 16'd5000, 16'd0, 16'd300, 1'b0);
    random_items(420);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    apply_setting(16'd8000, 16'd12000, 16'd100, 16'd3000, 1'b1);
    random_items(150);
    hold_left = 400;
    random_items(100);
    drain();
    random_items(170);

    drain();
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.result_q.size() == 0) begin
      $display("battery_undervoltage_monitor test passed");
    end else begin
      $display("battery_undervoltage_monitor test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("battery_undervoltage_monitor test failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bum_pkg.sv
rtl/bum_history.sv
rtl/battery_undervoltage_monitor.sv
bench/tb.sv
